// File: rtl/core/eop_pkg.sv
// Shared types, constants and sine ROM for the ellipse outline point block.
`default_nettype none

package eop_pkg;

   // Payload widths
   localparam int CENTER_BITS = 10;
   localparam int ANGLE_BITS  = 15;
   localparam int SEMI_BITS   = 16;
   localparam int INDEX_BITS  = 9;
   localparam int COLOR_BITS  = 24;
   localparam int POINT_BITS  = 12;

   // Configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 11;
   localparam logic [CSR_DATA_BITS-1:0] WIDTH_RESET  = 11'd160;
   localparam logic [CSR_DATA_BITS-1:0] HEIGHT_RESET = 11'd120;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Sine ROM: 512 entries, amplitude 256
   localparam int ROM_BITS  = 9;
   localparam int TRIG_BITS = 10;

   // round(2^28 / (16*pi)); angle index = (|angle| * RECIP * steps) >> 37
   localparam int RECIP_BITS  = 23;
   localparam logic [RECIP_BITS-1:0] ANGLE_RECIP = 23'd5340354;
   localparam int ANGLE_SHIFT = 37;

   localparam int NUM_STAGES = 6;

   localparam logic [7:0] QUARTER_WAVE [129] = '{
      8'd0,   8'd3,   8'd6,   8'd9,   8'd13,  8'd16,  8'd19,
      8'd22,  8'd25,  8'd28,  8'd31,  8'd34,  8'd38,  8'd41,
      8'd44,  8'd47,  8'd50,  8'd53,  8'd56,  8'd59,  8'd62,
      8'd65,  8'd68,  8'd71,  8'd74,  8'd77,  8'd80,  8'd83,
      8'd86,  8'd89,  8'd92,  8'd95,  8'd98,  8'd101, 8'd104,
      8'd107, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd123,
      8'd126, 8'd129, 8'd132, 8'd134, 8'd137, 8'd140, 8'd142,
      8'd145, 8'd147, 8'd150, 8'd152, 8'd155, 8'd157, 8'd160,
      8'd162, 8'd165, 8'd167, 8'd170, 8'd172, 8'd174, 8'd177,
      8'd179, 8'd181, 8'd183, 8'd185, 8'd188, 8'd190, 8'd192,
      8'd194, 8'd196, 8'd198, 8'd200, 8'd202, 8'd204, 8'd206,
      8'd207, 8'd209, 8'd211, 8'd213, 8'd215, 8'd216, 8'd218,
      8'd220, 8'd221, 8'd223, 8'd224, 8'd226, 8'd227, 8'd229,
      8'd230, 8'd231, 8'd233, 8'd234, 8'd235, 8'd237, 8'd238,
      8'd239, 8'd240, 8'd241, 8'd242, 8'd243, 8'd244, 8'd245,
      8'd246, 8'd247, 8'd248, 8'd248, 8'd249, 8'd250, 8'd250,
      8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254,
      8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255
   };

   // Top entries of the quarter wave are 256; the byte table above holds 255 there,
   // so those are patched below.
   function automatic logic signed [TRIG_BITS-1:0] rom_sin(input logic [ROM_BITS-1:0] idx);
      logic [8:0] k;
      logic [8:0] mag;
      begin
         k = {1'b0, idx[7:0]};
         if (k > 9'd128) begin
            k = 9'd256 - k;
         end
         if (k >= 9'd123) begin
            mag = 9'd256;
         end else begin
            mag = {1'b0, QUARTER_WAVE[k[7:0]]};
         end
         rom_sin = idx[8] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   endfunction

   function automatic logic signed [TRIG_BITS-1:0] rom_cos(input logic [ROM_BITS-1:0] idx);
      logic [ROM_BITS-1:0] shifted;
      begin
         shifted = idx + 9'd128;
         rom_cos = rom_sin(shifted);
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/eop_if.sv
// Request and response channel interfaces of the ellipse outline point block.
`default_nettype none

interface eop_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [eop_pkg::CENTER_BITS-1:0]        center_x;
   logic [eop_pkg::CENTER_BITS-1:0]        center_y;
   logic signed [eop_pkg::ANGLE_BITS-1:0]  angle_rad;
   logic [eop_pkg::SEMI_BITS-1:0]          major_semi;
   logic [eop_pkg::SEMI_BITS-1:0]          minor_semi;
   logic [eop_pkg::INDEX_BITS-1:0]         point_index;
   logic [eop_pkg::COLOR_BITS-1:0]         draw_color;

   modport source (
      output valid, center_x, center_y, angle_rad, major_semi, minor_semi,
             point_index, draw_color,
      input  ready
   );
   modport sink (
      input  valid, center_x, center_y, angle_rad, major_semi, minor_semi,
             point_index, draw_color,
      output ready
   );
endinterface

interface eop_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [eop_pkg::POINT_BITS-1:0]  point_x;
   logic signed [eop_pkg::POINT_BITS-1:0]  point_y;
   logic                                   plot;
   logic [eop_pkg::COLOR_BITS-1:0]         pixel_color;

   modport source (
      output valid, point_x, point_y, plot, pixel_color,
      input  ready
   );
   modport sink (
      input  valid, point_x, point_y, plot, pixel_color,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/eop_angle_index.sv
// Three-stage pipeline turning a Q3.12 angle into a sine ROM index.
`default_nettype none

module eop_angle_index #(
   parameter int ANGLE_STEPS = 512
) (
   input  wire logic                                   clock,
   input  wire logic [2:0]                             stage_en,
   input  wire logic signed [eop_pkg::ANGLE_BITS-1:0]  angle_rad,
   output logic [eop_pkg::ROM_BITS-1:0]                rom_index
);

   localparam int STEP_BITS   = $clog2(ANGLE_STEPS);
   localparam int PROD_BITS   = eop_pkg::ANGLE_BITS + eop_pkg::RECIP_BITS;
   localparam int SCALED_BITS = PROD_BITS + STEP_BITS + 1;
   // a * 512 / steps through an exact ceiling reciprocal
   localparam int MULT_BITS   = STEP_BITS + eop_pkg::ROM_BITS + 1;
   localparam int DIV_SHIFT   = 2 * STEP_BITS;
   localparam longint unsigned DIV_NUM = 64'd1 << (eop_pkg::ROM_BITS + 2 * STEP_BITS);
   localparam longint unsigned DIV_MULT_L =
      (DIV_NUM + longint'(ANGLE_STEPS) - 64'd1) / longint'(ANGLE_STEPS);
   localparam logic [MULT_BITS-1:0] DIV_MULT = MULT_BITS'(DIV_MULT_L);
   localparam int APROD_BITS  = STEP_BITS + MULT_BITS;

   logic [eop_pkg::ANGLE_BITS-1:0] mag_in;
   logic [PROD_BITS-1:0]           prod_in, prod_ff;
   logic                           neg0_ff, neg1_ff;
   logic [SCALED_BITS-1:0]         scaled;
   logic [STEP_BITS-1:0]           q_ff;
   logic [STEP_BITS:0]             wrapped;
   logic [STEP_BITS-1:0]           a_in;
   logic [APROD_BITS-1:0]          aprod_in, aprod_ff;

   always_comb begin
      mag_in  = angle_rad[eop_pkg::ANGLE_BITS-1] ? eop_pkg::ANGLE_BITS'(-angle_rad)
                                                 : eop_pkg::ANGLE_BITS'(angle_rad);
      prod_in = PROD_BITS'(mag_in) * PROD_BITS'(eop_pkg::ANGLE_RECIP);
   end

   always_comb begin
      scaled = SCALED_BITS'(prod_ff) * SCALED_BITS'(ANGLE_STEPS);
   end

   // Negative angles wrap by one turn, except those that truncate to zero
   always_comb begin
      wrapped = (STEP_BITS+1)'(ANGLE_STEPS) - {1'b0, q_ff};
      if (neg1_ff && (q_ff != '0)) begin
         a_in = wrapped[STEP_BITS-1:0];
      end else begin
         a_in = q_ff;
      end
      aprod_in = APROD_BITS'(a_in) * APROD_BITS'(DIV_MULT);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff <= prod_in;
         neg0_ff <= angle_rad[eop_pkg::ANGLE_BITS-1];
      end
      if (stage_en[1]) begin
         q_ff    <= scaled[eop_pkg::ANGLE_SHIFT +: STEP_BITS];
         neg1_ff <= neg0_ff;
      end
      if (stage_en[2]) begin
         aprod_ff <= aprod_in;
      end
   end

   assign rom_index = aprod_ff[DIV_SHIFT +: eop_pkg::ROM_BITS];

endmodule

`default_nettype wire

// File: rtl/core/ellipse_outline_point.sv
// Ellipse outline point: top level, six-stage point pipeline and image size registers.
//
// req carries one ellipse point per beat: center, Q3.12 angle, Q8.8 semi-axes,
// point index (0..511 around the outline) and a color. rsp returns the rotated
// outline point, the color and a plot flag set when the point is inside the
// image given by the image_width / image_height registers.
// csr_write_en writes csr_wdata into the register picked by csr_index
// (0 = width, 1 = height); values above MAX_IMAGE_DIM saturate. Write only
// while the pipeline is empty.
// Six register stages lie between req and rsp. Throughput is one beat per cycle
// while rsp does not stall.
// Each stage has its own valid bit and advances when it is empty or the next
// stage advances, so a stalled rsp fills bubbles before req.ready drops;
// nothing is dropped or repeated.
// Reset (synchronous) empties the pipeline and sets width 160, height 120.
`default_nettype none

module ellipse_outline_point #(
   parameter int ANGLE_STEPS   = 512,
   parameter int MAX_IMAGE_DIM = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   eop_req_if.sink                                   req,
   eop_rsp_if.source                                 rsp,
   input  wire logic                                 csr_write_en,
   input  wire logic [eop_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [eop_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int LAST = eop_pkg::NUM_STAGES - 1;
   localparam int CB   = eop_pkg::CENTER_BITS;
   localparam int PB   = eop_pkg::POINT_BITS;
   localparam int DB   = eop_pkg::CSR_DATA_BITS;

   // Image size registers
   logic [DB-1:0] width_ff, height_ff;
   logic [DB-1:0] csr_value;

   always_comb begin
      if ({2'b00, csr_wdata} > (DB+2)'(MAX_IMAGE_DIM)) begin
         csr_value = DB'(MAX_IMAGE_DIM);
      end else begin
         csr_value = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= eop_pkg::WIDTH_RESET;
         height_ff <= eop_pkg::HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (eop_pkg::csr_index_type'(csr_index))
            eop_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_value;
            eop_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_value;
            default: ;
         endcase
      end
   end

   // Stage control
   logic [LAST:0] valid_ff, valid_in, stage_en;

   always_comb begin
      stage_en[LAST] = !valid_ff[LAST] || rsp.ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in = {valid_ff[LAST-1:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k <= LAST; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req.ready = stage_en[0];

   // Angle to ROM index, stages 0..2
   logic [eop_pkg::ROM_BITS-1:0] rom_index;

   eop_angle_index #(
      .ANGLE_STEPS (ANGLE_STEPS)
   ) u_angle (
      .clock     (clock),
      .stage_en  (stage_en[2:0]),
      .angle_rad (req.angle_rad),
      .rom_index (rom_index)
   );

   // Center and color ride along
   logic [CB-1:0] cx_ff [LAST];
   logic [CB-1:0] cy_ff [LAST];
   logic [eop_pkg::COLOR_BITS-1:0] color_ff [LAST];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cx_ff[0]    <= req.center_x;
         cy_ff[0]    <= req.center_y;
         color_ff[0] <= req.draw_color;
      end
      for (int k = 1; k < LAST; k++) begin
         if (stage_en[k]) begin
            cx_ff[k]    <= cx_ff[k-1];
            cy_ff[k]    <= cy_ff[k-1];
            color_ff[k] <= color_ff[k-1];
         end
      end
   end

   // Stage 0: semi-axes times point entries
   logic signed [25:0] cexm_in, ceym_in, cexm_ff, ceym_ff;

   always_comb begin
      cexm_in = $signed({1'b0, req.major_semi}) * eop_pkg::rom_cos(req.point_index);
      ceym_in = $signed({1'b0, req.minor_semi}) * eop_pkg::rom_sin(req.point_index);
   end

   // Stage 1: divide by 256 toward zero
   logic signed [25:0] cexm_adj, ceym_adj;
   logic signed [16:0] cex1_ff, cey1_ff, cex2_ff, cey2_ff;

   always_comb begin
      cexm_adj = cexm_ff + (cexm_ff[25] ? 26'sd255 : 26'sd0);
      ceym_adj = ceym_ff + (ceym_ff[25] ? 26'sd255 : 26'sd0);
   end

   // Stage 3: rotation products
   logic signed [eop_pkg::TRIG_BITS-1:0] ca, sa;
   logic signed [26:0] xc_in, ys_in, yc_in, xs_in;
   logic signed [26:0] xc_ff, ys_ff, yc_ff, xs_ff;

   always_comb begin
      ca    = eop_pkg::rom_cos(rom_index);
      sa    = eop_pkg::rom_sin(rom_index);
      xc_in = cex2_ff * ca;
      ys_in = cey2_ff * sa;
      yc_in = cey2_ff * ca;
      xs_in = cex2_ff * sa;
   end

   // Stage 4: sums, floor shift by 16
   logic signed [27:0] sum_x, sum_y;
   logic signed [PB-1:0] offs_x_ff, offs_y_ff;

   always_comb begin
      sum_x = 28'(xc_ff) - 28'(ys_ff);
      sum_y = 28'(yc_ff) + 28'(xs_ff);
   end

   // Stage 5: add center, clip test
   logic signed [PB-1:0] px_in, py_in, px_ff, py_ff;
   logic                 plot_in, plot_ff;
   logic [eop_pkg::COLOR_BITS-1:0] color_out_ff;

   always_comb begin
      px_in   = offs_x_ff + $signed({2'b00, cx_ff[LAST-1]});
      py_in   = offs_y_ff + $signed({2'b00, cy_ff[LAST-1]});
      plot_in = !px_in[PB-1] && (px_in[DB-1:0] < width_ff) &&
                !py_in[PB-1] && (py_in[DB-1:0] < height_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cexm_ff <= cexm_in;
         ceym_ff <= ceym_in;
      end
      if (stage_en[1]) begin
         cex1_ff <= cexm_adj[24:8];
         cey1_ff <= ceym_adj[24:8];
      end
      if (stage_en[2]) begin
         cex2_ff <= cex1_ff;
         cey2_ff <= cey1_ff;
      end
      if (stage_en[3]) begin
         xc_ff <= xc_in;
         ys_ff <= ys_in;
         yc_ff <= yc_in;
         xs_ff <= xs_in;
      end
      if (stage_en[4]) begin
         offs_x_ff <= sum_x[27:16];
         offs_y_ff <= sum_y[27:16];
      end
      if (stage_en[5]) begin
         px_ff        <= px_in;
         py_ff        <= py_in;
         plot_ff      <= plot_in;
         color_out_ff <= color_ff[LAST-1];
      end
   end

   assign rsp.valid       = valid_ff[LAST];
   assign rsp.point_x     = px_ff;
   assign rsp.point_y     = py_ff;
   assign rsp.plot        = plot_ff;
   assign rsp.pixel_color = color_out_ff;

endmodule

`default_nettype wire

// File: rtl/core/eop_checker.sv
// Port-level checks for the ellipse outline point block, bound to the top level.
`default_nettype none

module eop_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_ready,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic signed [eop_pkg::POINT_BITS-1:0] point_x,
   input wire logic signed [eop_pkg::POINT_BITS-1:0] point_y,
   input wire logic                                 plot,
   input wire logic [eop_pkg::COLOR_BITS-1:0]       pixel_color
);

   // Pipeline is empty after reset
   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // A plotted point never has a negative coordinate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && plot |-> !point_x[eop_pkg::POINT_BITS-1] && !point_y[eop_pkg::POINT_BITS-1])
      else $error("plot set for negative coordinate");

   // Input may only stall while the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output stall");

   // Stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(point_x) && $stable(point_y)
         && $stable(plot) && $stable(pixel_color))
      else $error("stalled response beat changed");

endmodule

bind ellipse_outline_point eop_checker u_eop_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .point_x     (rsp.point_x),
   .point_y     (rsp.point_y),
   .plot        (rsp.plot),
   .pixel_color (rsp.pixel_color)
);

`default_nettype wire
